/* hdl/hash_table_depth_replace_assert.svh */
// Assertion macros for the hash table block.
// Needs a clock named clk_i and an active-low reset named rst_ni in the including module.
`ifndef HASH_TABLE_DEPTH_REPLACE_ASSERT_SVH
`define HASH_TABLE_DEPTH_REPLACE_ASSERT_SVH

// Checked only outside reset.
`define HTDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define HTDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/htdr_pkg.sv */
// Types and constants for the direct-mapped position table.
// No dependencies; imported by hash_table_depth_replace.
`default_nettype none

package htdr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned CFG_W           = 13;
  localparam logic [CFG_W-1:0] CFG_RESET  = 13'd4096;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned HALF_W          = KEY_W / 2;

  typedef enum logic [1:0] {
    FUNC_PROBE = 2'd0,
    FUNC_STORE = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_EVAL
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [KEY_W-1:0]   key;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [7:0]         depth;
    logic [7:0]         flag;
    logic               from_qs;
    logic signed [15:0] eval;
  } ht_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] hit_score;
    logic [15:0]        hit_move;
    logic [7:0]         hit_depth;
    logic [7:0]         hit_flag;
    logic               hit_qsearch;
    logic signed [15:0] hit_eval;
  } ht_out_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [7:0]         depth;
    logic [7:0]         flag;
    logic               qsearch;
    logic signed [15:0] eval;
  } slot_t;

endpackage

`default_nettype wire

/* hdl/hash_table_depth_replace.sv */
// Direct-mapped position table: probe, depth-preferred store, clear all.
// Uses htdr_pkg and the assertion macros in hash_table_depth_replace_assert.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_data_i) carries one operation item:
//   probe, store or clear. Output channel (out_valid_o/out_ready_i, out_data_o)
//   returns exactly one result item per input item, in order; only a probe hit
//   gives nonzero fields.
//   cfg_we_i/cfg_wdata_i set the number of slots in use; write only while idle.
//   A probe or store passes ST_MUL and ST_ADDR (split 64x13 index multiply),
//   ST_READ (slot memory read) and ST_EVAL (compare/write-back, result posted
//   to the output register), then returns to ST_IDLE, where the next item is
//   taken; a new item is not taken before the last one is through.
//   A clear posts its result the same way, then sweeps all TABLE_DEPTH slot
//   memory entries, one entry per cycle, before the next item is taken.
//   Reset runs the same sweep with in_ready_o low; configuration writes are
//   taken during it.
//   A stalled receiver holds the finished result in the output register; one
//   further item is accepted and worked up to its write-back, where it waits.
`default_nettype none

module hash_table_depth_replace #(
  parameter int unsigned TABLE_DEPTH = htdr_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [htdr_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire htdr_pkg::ht_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output htdr_pkg::ht_out_t                out_data_o
);
  import htdr_pkg::*;

  `include "hash_table_depth_replace_assert.svh"

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PP_W  = HALF_W + CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_e            state_q, state_d;
  ht_in_t            in_q;
  logic [CFG_W-1:0]  cfg_q;
  logic [CFG_W-1:0]  n_used;
  logic              n_zero;
  logic [PP_W-1:0]   pp_lo_q, pp_hi_q;
  logic [PP_W:0]     pp_sum;
  logic [IDX_W-1:0]  slot_q;
  logic [IDX_W-1:0]  clr_cnt_q, clr_cnt_d;
  slot_t             slot_mem [TABLE_DEPTH];
  slot_t             rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  slot_t             mem_wdata;
  ht_out_t           out_q, out_d;
  logic              out_valid_q;
  logic              out_free;
  logic              out_load;
  logic              rd_same;
  logic              st_refuse;
  logic              st_full;

  // Slots in use, saturated at the table size.
  always_comb begin
    if (32'(cfg_q) > 32'(TABLE_DEPTH)) begin
      n_used = CFG_W'(TABLE_DEPTH);
    end else begin
      n_used = cfg_q;
    end
    n_zero = (n_used == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Index = key * n >> 64 (the product bits above bit 63), from the partial products of the two 32-bit key halves.
  assign pp_sum = (PP_W + 1)'(pp_hi_q) + (PP_W + 1)'(pp_lo_q >> HALF_W);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (state_q == ST_MUL) begin
      pp_lo_q <= PP_W'(in_q.key[HALF_W-1:0]) * PP_W'(n_used);
      pp_hi_q <= PP_W'(in_q.key[KEY_W-1:HALF_W]) * PP_W'(n_used);
    end
    if (state_q == ST_ADDR) begin
      slot_q <= IDX_W'(pp_sum[HALF_W +: CFG_W]);
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= slot_mem[slot_q];
  end

  // Replacement decision on the slot just read.
  always_comb begin
    rd_same   = rd_q.valid && (rd_q.key == in_q.key);
    st_refuse = rd_q.valid && !rd_same && in_q.from_qs && !rd_q.qsearch;
    st_full   = !rd_q.valid || !rd_same || (in_q.depth >= rd_q.depth);
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_ADDR;
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (out_free) begin
          if (in_q.func == FUNC_CLEAR) begin
            state_d   = ST_CLEAR;
            clr_cnt_d = '0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = slot_q;
    mem_wdata  = rd_q;
    out_load   = 1'b0;
    out_d      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clr_cnt_q;
        mem_wdata.valid = 1'b0;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_EVAL: begin
        if (out_free) begin
          out_load = 1'b1;
          if (in_q.func == FUNC_PROBE && !n_zero && rd_same) begin
            out_d.hit         = 1'b1;
            out_d.hit_score   = rd_q.score;
            out_d.hit_move    = rd_q.move;
            out_d.hit_depth   = rd_q.depth;
            out_d.hit_flag    = rd_q.flag;
            out_d.hit_qsearch = rd_q.qsearch;
            out_d.hit_eval    = rd_q.eval;
          end
          if (in_q.func == FUNC_STORE && !n_zero && !st_refuse) begin
            mem_we = 1'b1;
            if (st_full) begin
              mem_wdata.valid   = 1'b1;
              mem_wdata.key     = in_q.key;
              mem_wdata.score   = in_q.score;
              mem_wdata.move    = in_q.move;
              mem_wdata.depth   = in_q.depth;
              mem_wdata.flag    = in_q.flag;
              mem_wdata.qsearch = in_q.from_qs;
              mem_wdata.eval    = in_q.eval;
            end else begin
              // same key at lower depth: refresh eval only
              mem_wdata.eval = in_q.eval;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HTDR_ASSERT(a_no_write_on_accept, (in_valid_i && in_ready_o) |-> !mem_we, "write during accept")
  `HTDR_ASSERT(a_post_from_eval, $rose(out_valid_o) |-> $past(state_q == ST_EVAL), "late post")
  `HTDR_ASSERT(a_clear_starts_at_zero, (out_load && in_q.func == FUNC_CLEAR) |=> (state_q == ST_CLEAR && clr_cnt_q == '0), "clear sweep not started")
  `HTDR_ASSERT(a_no_overwrite_result, (out_load && out_valid_q) |-> out_ready_i, "result overwritten")
  `HTDR_ASSERT_ALWAYS(a_ready_only_idle, in_ready_o |-> (state_q == ST_IDLE), "ready outside idle")

endmodule

`default_nettype wire
